// ----- design/mseu_pkg.sv -----
// Package for the MIPS subset execute unit: status, command, opcode, function
// and syscall codes, register and CSR indexes and the sequencer state type.
// No dependencies.
package mseu_pkg;

   localparam logic [1:0] CMD_EXEC    = 2'd0;
   localparam logic [1:0] CMD_LOAD    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_HALT     = 4'd1;
   localparam logic [3:0] ST_PRINT    = 4'd2;
   localparam logic [3:0] ST_READ     = 4'd3;
   localparam logic [3:0] ST_BADPC    = 4'd4;
   localparam logic [3:0] ST_DIVZ     = 4'd5;
   localparam logic [3:0] ST_BADREF   = 4'd6;
   localparam logic [3:0] ST_BADINSTR = 4'd7;
   localparam logic [3:0] ST_STOPPED  = 4'd8;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_SW      = 6'd43;

   localparam logic [5:0] FN_SYSCALL = 6'd12;
   localparam logic [5:0] FN_MFHI    = 6'd16;
   localparam logic [5:0] FN_MFLO    = 6'd18;
   localparam logic [5:0] FN_MULT    = 6'd24;
   localparam logic [5:0] FN_DIV     = 6'd26;
   localparam logic [5:0] FN_ADDU    = 6'd33;
   localparam logic [5:0] FN_SUBU    = 6'd35;
   localparam logic [5:0] FN_AND     = 6'd36;
   localparam logic [5:0] FN_OR      = 6'd37;
   localparam logic [5:0] FN_SLT     = 6'd42;

   localparam logic [31:0] SYS_PRINT = 32'd1;
   localparam logic [31:0] SYS_READ  = 32'd5;
   localparam logic [31:0] SYS_EXIT  = 32'd10;

   localparam logic [4:0] REG_ZERO = 5'd0;
   localparam logic [4:0] REG_V0   = 5'd2;
   localparam logic [4:0] REG_A0   = 5'd4;
   localparam logic [4:0] REG_GP   = 5'd28;

   localparam logic CSR_LAST_INDEX = 1'b0;
   localparam logic CSR_DATA_WORDS = 1'b1;

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,
      S_RRS  = 12'b0000_0000_0010,
      S_RRT  = 12'b0000_0000_0100,
      S_RV0  = 12'b0000_0000_1000,
      S_RA0  = 12'b0000_0001_0000,
      S_RGP  = 12'b0000_0010_0000,
      S_EXEC = 12'b0000_0100_0000,
      S_MUL  = 12'b0000_1000_0000,
      S_DIV  = 12'b0001_0000_0000,
      S_DFIX = 12'b0010_0000_0000,
      S_LW   = 12'b0100_0000_0000,
      S_FIN  = 12'b1000_0000_0000
   } state_type;

endpackage

// ----- design/mseu_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mseu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- design/mips_subset_execute_unit.sv -----
// MIPS subset execute unit: one instruction, data load or restart per item.
// Load, restart and stop cases go from idle straight to the finish state; most
// instructions pass five register file reads through one port and an execute
// state, mult adds S_MUL, lw adds S_LW and div runs a 32-step shift-subtract
// divider and S_DFIX. One item at a time. Synchronous active-high reset clears
// registers, hi, lo, pc and the stop flag; the data store is not cleared.
module mips_subset_execute_unit
   import mseu_pkg::*;
#(
   parameter int INSTR_WORDS = 32768,
   parameter int DATA_WORDS  = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [31:0]        req_instr_word,
   input  logic [9:0]         req_load_index,
   input  logic [31:0]        req_load_value,
   input  logic signed [31:0] req_console_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_status,
   output logic [14:0]        rsp_executed_pc,
   output logic [14:0]        rsp_next_pc,
   output logic signed [31:0] rsp_print_value,
   output logic               rsp_reg_written,
   output logic [4:0]         rsp_reg_index,
   output logic signed [31:0] rsp_reg_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [14:0]        csr_data
);
   localparam int DW_AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

   state_type state_ff, state_in;

   logic [14:0] last_index_ff;
   logic [10:0] dwu_ff;
   logic [14:0] pc_ff, epc_ff;
   logic        stopped_ff;
   logic [31:0] hi_ff, lo_ff;
   logic [31:0] rv_ff;
   logic [4:0]  rd_addr_ff;

   logic [31:0] word_ff, console_ff;
   logic [31:0] a_ff, b_ff, v0_ff, a0_ff;
   logic [3:0]  st_ff;
   logic [14:0] npc_ff;
   logic [31:0] pval_ff;
   logic        wr_ff;
   logic [4:0]  widx_ff;
   logic [31:0] wval_ff;
   logic [63:0] prod_ff;
   logic [32:0] dv_rem_ff;
   logic [31:0] dv_q_ff, dv_d_ff;
   logic [4:0]  dv_cnt_ff;

   logic        out_valid_ff;
   logic [3:0]  out_status_ff;
   logic [14:0] out_epc_ff, out_npc_ff;
   logic [31:0] out_pval_ff;
   logic        out_wr_ff;
   logic [4:0]  out_widx_ff;
   logic [31:0] out_wval_ff;

   // Register file RAM; entries not written since restart read as zero.
   logic        rf_we;
   logic [4:0]  rf_waddr, rf_raddr;
   logic [31:0] rf_wdata, rf_rdata, rf_val;

   mseu_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
      .clock(clock), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
      .raddr(rf_raddr), .rdata(rf_rdata)
   );

   logic             dm_we;
   logic [DW_AW-1:0] dm_waddr, dm_raddr;
   logic [31:0]      dm_wdata, dm_rdata;

   mseu_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dm (
      .clock(clock), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
      .raddr(dm_raddr), .rdata(dm_rdata)
   );

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd;
   logic [15:0] imm;
   logic        accept, fin_go, err, commit_wr;
   logic [33:0] maddr;
   logic [16:0] mlim;
   logic        mok;
   logic [17:0] btgt;
   logic [32:0] dv_sh, dv_diff;
   logic [31:0] abs_a, abs_b;

   assign op  = word_ff[31:26];
   assign rs  = word_ff[25:21];
   assign rt  = word_ff[20:16];
   assign rd  = word_ff[15:11];
   assign fn  = word_ff[5:0];
   assign imm = word_ff[15:0];

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rf_val    = rv_ff[rd_addr_ff] ? rf_rdata : 32'd0;
   assign fin_go    = (state_ff == S_FIN) && !(out_valid_ff && rsp_stall);
   assign err       = (st_ff == ST_HALT) || (st_ff == ST_BADREF) || (st_ff == ST_DIVZ) ||
                      (st_ff == ST_BADINSTR) || (st_ff == ST_BADPC);
   assign commit_wr = wr_ff && (widx_ff != REG_ZERO) && !err;

   // Memory word index: rs - gp + offset, gp is on the read port in S_EXEC.
   assign maddr = {{2{a_ff[31]}}, a_ff} - {{2{rf_val[31]}}, rf_val} +
                  {{18{imm[15]}}, imm};
   assign mlim  = ({6'd0, dwu_ff} < 17'(DATA_WORDS)) ? {6'd0, dwu_ff} : 17'(DATA_WORDS);
   assign mok   = !maddr[33] && (maddr[32:17] == 16'd0) && (maddr[16:0] < mlim);
   assign btgt  = {3'd0, epc_ff} + {{2{imm[15]}}, imm};

   assign abs_a   = a_ff[31] ? (32'd0 - a_ff) : a_ff;
   assign abs_b   = b_ff[31] ? (32'd0 - b_ff) : b_ff;
   assign dv_sh   = {dv_rem_ff[31:0], dv_q_ff[31]};
   assign dv_diff = dv_sh - {1'b0, dv_d_ff};

   always_comb begin
      unique case (state_ff)
         S_RRS:   rf_raddr = rs;
         S_RRT:   rf_raddr = rt;
         S_RV0:   rf_raddr = REG_V0;
         S_RA0:   rf_raddr = REG_A0;
         S_RGP:   rf_raddr = REG_GP;
         default: rf_raddr = REG_ZERO;
      endcase
   end

   always_comb begin
      rf_we    = 1'b0;
      rf_waddr = widx_ff;
      rf_wdata = wval_ff;
      if (accept && (req_cmd == CMD_RESTART)) begin
         rf_we    = 1'b1;
         rf_waddr = REG_GP;
         rf_wdata = {17'd0, last_index_ff} + 32'd1;
      end else if (fin_go && commit_wr) begin
         rf_we = 1'b1;
      end
   end

   always_comb begin
      dm_raddr = DW_AW'(maddr[16:0]);
      dm_we    = 1'b0;
      dm_waddr = DW_AW'(maddr[16:0]);
      dm_wdata = b_ff;
      if (accept && (req_cmd == CMD_LOAD)) begin
         dm_we    = ({7'd0, req_load_index} < 17'(DATA_WORDS));
         dm_waddr = DW_AW'(req_load_index);
         dm_wdata = req_load_value;
      end else if ((state_ff == S_EXEC) && (op == OP_SW) && mok) begin
         dm_we = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((req_cmd == CMD_EXEC) && !stopped_ff && (pc_ff <= last_index_ff) &&
                   ({1'b0, pc_ff} < 16'(INSTR_WORDS))) begin
                  state_in = S_RRS;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_RRS: state_in = S_RRT;
         S_RRT: state_in = S_RV0;
         S_RV0: state_in = S_RA0;
         S_RA0: state_in = S_RGP;
         S_RGP: state_in = S_EXEC;
         S_EXEC: begin
            if (op == OP_SPECIAL && fn == FN_MULT) begin
               state_in = S_MUL;
            end else if (op == OP_SPECIAL && fn == FN_DIV && b_ff != 32'd0) begin
               state_in = S_DIV;
            end else if (op == OP_LW && mok) begin
               state_in = S_LW;
            end else begin
               state_in = S_FIN;
            end
         end
         S_MUL: state_in = S_FIN;
         S_DIV: state_in = (dv_cnt_ff == 5'd31) ? S_DFIX : S_DIV;
         S_DFIX: state_in = S_FIN;
         S_LW: state_in = S_FIN;
         S_FIN: state_in = fin_go ? S_IDLE : S_FIN;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_index_ff <= 15'd0;
         dwu_ff        <= 11'd0;
         pc_ff         <= 15'd0;
         stopped_ff    <= 1'b0;
         hi_ff         <= 32'd0;
         lo_ff         <= 32'd0;
         rv_ff         <= 32'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LAST_INDEX: last_index_ff <= csr_data;
               CSR_DATA_WORDS: dwu_ff <= csr_data[10:0];
            endcase
         end
         if (accept && (req_cmd == CMD_RESTART)) begin
            rv_ff      <= 32'd1 << REG_GP;
            hi_ff      <= 32'd0;
            lo_ff      <= 32'd0;
            pc_ff      <= 15'd0;
            stopped_ff <= 1'b0;
         end
         if (state_ff == S_MUL) begin
            hi_ff <= prod_ff[63:32];
            lo_ff <= prod_ff[31:0];
         end
         if (state_ff == S_DFIX) begin
            lo_ff <= (a_ff[31] ^ b_ff[31]) ? (32'd0 - dv_q_ff) : dv_q_ff;
            hi_ff <= a_ff[31] ? (32'd0 - dv_rem_ff[31:0]) : dv_rem_ff[31:0];
         end
         if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (fin_go) begin
            out_valid_ff <= 1'b1;
            pc_ff        <= err ? epc_ff : npc_ff;
            if (err) begin
               stopped_ff <= 1'b1;
            end
            if (commit_wr) begin
               rv_ff[widx_ff] <= 1'b1;
            end
         end
      end
   end

   // Datapath registers, no reset needed.
   always_ff @(posedge clock) begin
      rd_addr_ff <= rf_raddr;
      if (accept) begin
         word_ff    <= req_instr_word;
         console_ff <= req_console_value;
         epc_ff     <= (req_cmd == CMD_RESTART) ? 15'd0 : pc_ff;
         npc_ff     <= (req_cmd == CMD_RESTART) ? 15'd0 : pc_ff;
         pval_ff    <= 32'd0;
         wr_ff      <= 1'b0;
         widx_ff    <= REG_ZERO;
         wval_ff    <= 32'd0;
         st_ff      <= ST_OK;
         if (req_cmd == CMD_EXEC) begin
            if (stopped_ff) begin
               st_ff <= ST_STOPPED;
            end else if ((pc_ff > last_index_ff) ||
                         ({1'b0, pc_ff} >= 16'(INSTR_WORDS))) begin
               st_ff <= ST_BADPC;
            end
         end
      end
      unique case (state_ff)
         S_RRT: a_ff  <= rf_val;
         S_RV0: b_ff  <= rf_val;
         S_RA0: v0_ff <= rf_val;
         S_RGP: a0_ff <= rf_val;
         default: ;
      endcase
      if (state_ff == S_EXEC) begin
         npc_ff    <= epc_ff + 15'd1;
         prod_ff   <= 64'($signed(a_ff) * $signed(b_ff));
         dv_q_ff   <= abs_a;
         dv_d_ff   <= abs_b;
         dv_rem_ff <= 33'd0;
         dv_cnt_ff <= 5'd0;
         widx_ff   <= rd;
         priority case (op)
            OP_SPECIAL: begin
               priority case (fn)
                  FN_ADDU: begin wr_ff <= 1'b1; wval_ff <= a_ff + b_ff; end
                  FN_SUBU: begin wr_ff <= 1'b1; wval_ff <= a_ff - b_ff; end
                  FN_AND:  begin wr_ff <= 1'b1; wval_ff <= a_ff & b_ff; end
                  FN_OR:   begin wr_ff <= 1'b1; wval_ff <= a_ff | b_ff; end
                  FN_SLT: begin
                     wr_ff   <= 1'b1;
                     wval_ff <= {31'd0, $signed(a_ff) < $signed(b_ff)};
                  end
                  FN_MFHI: begin wr_ff <= 1'b1; wval_ff <= hi_ff; end
                  FN_MFLO: begin wr_ff <= 1'b1; wval_ff <= lo_ff; end
                  FN_DIV: begin
                     if (b_ff == 32'd0) begin
                        st_ff <= ST_DIVZ;
                     end
                  end
                  FN_SYSCALL: begin
                     if (v0_ff == SYS_PRINT) begin
                        st_ff   <= ST_PRINT;
                        pval_ff <= a0_ff;
                     end else if (v0_ff == SYS_READ) begin
                        st_ff   <= ST_READ;
                        wr_ff   <= 1'b1;
                        widx_ff <= REG_V0;
                        wval_ff <= console_ff;
                     end else if (v0_ff == SYS_EXIT) begin
                        st_ff <= ST_HALT;
                     end
                  end
                  default: ;
               endcase
            end
            OP_J: begin
               if ({11'd0, last_index_ff} >= word_ff[25:0]) begin
                  npc_ff <= word_ff[14:0];
               end
            end
            OP_BEQ, OP_BNE: begin
               if (((op == OP_BEQ) == (a_ff == b_ff)) && !btgt[17] &&
                   (btgt[16:0] <= {2'd0, last_index_ff})) begin
                  npc_ff <= btgt[14:0];
               end
            end
            OP_ADDIU: begin
               wr_ff   <= 1'b1;
               widx_ff <= rt;
               wval_ff <= a_ff + {{16{imm[15]}}, imm};
            end
            OP_LW, OP_SW: begin
               widx_ff <= rt;
               if (!mok) begin
                  st_ff <= ST_BADREF;
               end
            end
            default: st_ff <= ST_BADINSTR;
         endcase
      end
      if (state_ff == S_DIV) begin
         dv_cnt_ff <= dv_cnt_ff + 5'd1;
         dv_q_ff   <= {dv_q_ff[30:0], !dv_diff[32]};
         dv_rem_ff <= dv_diff[32] ? dv_sh : dv_diff;
      end
      if (state_ff == S_LW) begin
         wr_ff   <= 1'b1;
         wval_ff <= dm_rdata;
      end
      if (fin_go) begin
         out_status_ff <= st_ff;
         out_epc_ff    <= epc_ff;
         out_npc_ff    <= err ? epc_ff : npc_ff;
         out_pval_ff   <= err ? 32'd0 : pval_ff;
         out_wr_ff     <= commit_wr;
         out_widx_ff   <= commit_wr ? widx_ff : REG_ZERO;
         out_wval_ff   <= commit_wr ? wval_ff : 32'd0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_executed_pc = out_epc_ff;
   assign rsp_next_pc     = out_npc_ff;
   assign rsp_print_value = out_pval_ff;
   assign rsp_reg_written = out_wr_ff;
   assign rsp_reg_index   = out_widx_ff;
   assign rsp_reg_value   = out_wval_ff;
endmodule
